// ----- hw/rtl/sdu_pkg.sv -----
// ----------------------------------------------------------------------------
// sdu_pkg
// Shared types for the sorted distinct union set unit: command and result
// words, control state encoding and the per-cell control group.
// ----------------------------------------------------------------------------
package sdu_pkg;

    localparam int unsigned DATA_W = 32;

    typedef enum logic
    {
        KIND_INSERT = 1'b0,
        KIND_FLUSH  = 1'b1
    } kind_t;

    typedef struct packed
    {
        kind_t                     kind;
        logic signed [DATA_W-1:0]  value;
    } cmd_word_t;

    typedef struct packed
    {
        logic signed [DATA_W-1:0]  value_res;
        logic                      last;
        logic                      empty_res;
        logic                      overflow;
    } res_word_t;

    typedef enum logic [1:0]
    {
        ST_IDLE  = 2'd0,
        ST_INS   = 2'd1,
        ST_FLUSH = 2'd2
    } state_t;

    typedef struct packed
    {
        logic ins;
        logic shl;
    } cell_ctl_t;

endpackage

// ----- hw/rtl/sdu_cell.sv -----
// ----------------------------------------------------------------------------
// sdu_cell
// One storage cell of the sorted chain. Compares the broadcast insert value
// with its own entry, takes the new value or its left neighbor's entry on an
// insert, and takes its right neighbor's entry on a drain shift.
// ----------------------------------------------------------------------------
module sdu_cell
(
    input  logic                               clk,
    input  logic                               rst_n,
    input  sdu_pkg::cell_ctl_t                 ctl,
    input  logic signed [sdu_pkg::DATA_W-1:0]  ins_val,
    input  logic signed [sdu_pkg::DATA_W-1:0]  left_val,
    input  logic                               left_take,
    input  logic                               left_valid,
    input  logic signed [sdu_pkg::DATA_W-1:0]  right_val,
    input  logic                               right_valid,
    output logic signed [sdu_pkg::DATA_W-1:0]  val,
    output logic                               valid,
    output logic                               take,
    output logic                               eq
);
    import sdu_pkg::*;

    logic signed [DATA_W-1:0] val_reg;
    logic signed [DATA_W-1:0] val_next;
    logic                     valid_reg;
    logic                     valid_next;
    logic                     lt;

    assign lt    = valid_reg && (ins_val < val_reg);
    assign eq    = valid_reg && (ins_val == val_reg);
    assign take  = lt || !valid_reg;
    assign val   = val_reg;
    assign valid = valid_reg;

    always_comb
    begin
        val_next   = val_reg;
        valid_next = valid_reg;
        if (ctl.shl)
        begin
            val_next   = right_val;
            valid_next = right_valid;
        end
        else if (ctl.ins)
        begin
            valid_next = valid_reg || left_valid;
            if (take)
            begin
                val_next = left_take ? left_val : ins_val;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        val_reg <= val_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

endmodule

// ----- hw/rtl/sorted_distinct_union_set_unit.sv -----
// ----------------------------------------------------------------------------
// sorted_distinct_union_set_unit
// Keeps an ascending, duplicate-free set of signed words in a chain of
// compare-and-shift cells and drains it in order on a flush command.
//
//   channel  | handshake          | word        | direction
//   ---------+--------------------+-------------+----------
//   command  | start / busy       | cmd         | in
//   result   | strobe (1 cycle)   | res         | out
//
// Insert: accepted, then a compare-and-shift across all cells in ST_INS
//   (busy meanwhile); a duplicate is skipped and a full chain drops the value.
// Flush: n stored words leave one per cycle after the accept; a flush of
//   an empty set returns its one word in the cycle after the accept.
// The drain rate is set by one left shift per cycle; the receiver cannot stall.
// Reset clears all valid bits and the overflow flag; no clearing pass.
// ----------------------------------------------------------------------------
module sorted_distinct_union_set_unit
#(
    parameter int unsigned CAPACITY = 64
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  sdu_pkg::cmd_word_t  cmd,
    output logic                strobe,
    output sdu_pkg::res_word_t  res
);
    import sdu_pkg::*;

    state_t                   state_reg;
    state_t                   state_next;
    cell_ctl_t                ctl;
    logic signed [DATA_W-1:0] ins_reg;
    logic signed [DATA_W-1:0] ins_next;
    logic                     drop_reg;
    logic                     drop_next;
    logic                     strobe_reg;
    logic                     strobe_next;
    res_word_t                res_reg;
    res_word_t                res_next;
    logic                     accept;
    logic                     dup;
    logic                     full;

    logic signed [DATA_W-1:0] val_w [CAPACITY];
    logic [CAPACITY-1:0]      valid_w;
    logic [CAPACITY-1:0]      take_w;
    logic [CAPACITY-1:0]      eq_w;

    assign accept = start && (state_reg == ST_IDLE);
    assign busy   = (state_reg != ST_IDLE);
    assign dup    = |eq_w;
    assign full   = valid_w[CAPACITY-1];
    assign strobe = strobe_reg;
    assign res    = res_reg;

    genvar gi;
    generate
        for (gi = 0; gi < CAPACITY; gi++)
        begin : g_cell
            logic signed [DATA_W-1:0] l_val;
            logic                     l_take;
            logic                     l_valid;
            logic signed [DATA_W-1:0] r_val;
            logic                     r_valid;

            if (gi == 0)
            begin : g_head
                assign l_val   = '0;
                assign l_take  = 1'b0;
                assign l_valid = 1'b1;
            end
            else
            begin : g_body
                assign l_val   = val_w[gi-1];
                assign l_take  = take_w[gi-1];
                assign l_valid = valid_w[gi-1];
            end

            if (gi == CAPACITY - 1)
            begin : g_tail
                assign r_val   = '0;
                assign r_valid = 1'b0;
            end
            else
            begin : g_mid
                assign r_val   = val_w[gi+1];
                assign r_valid = valid_w[gi+1];
            end

            sdu_cell u_cell
            (
                .clk         (clk),
                .rst_n       (rst_n),
                .ctl         (ctl),
                .ins_val     (ins_reg),
                .left_val    (l_val),
                .left_take   (l_take),
                .left_valid  (l_valid),
                .right_val   (r_val),
                .right_valid (r_valid),
                .val         (val_w[gi]),
                .valid       (valid_w[gi]),
                .take        (take_w[gi]),
                .eq          (eq_w[gi])
            );
        end
    endgenerate

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (cmd.kind == KIND_INSERT)
                    begin
                        state_next = ST_INS;
                    end
                    else if (valid_w[0])
                    begin
                        state_next = ST_FLUSH;
                    end
                end
            end
            ST_INS:
            begin
                state_next = ST_IDLE;
            end
            ST_FLUSH:
            begin
                if (!valid_w[1])
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        ctl         = '0;
        ins_next    = ins_reg;
        drop_next   = drop_reg;
        strobe_next = 1'b0;
        res_next    = res_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    ins_next = cmd.value;
                    if ((cmd.kind == KIND_FLUSH) && !valid_w[0])
                    begin
                        strobe_next        = 1'b1;
                        res_next.value_res = '0;
                        res_next.last      = 1'b1;
                        res_next.empty_res = 1'b1;
                        res_next.overflow  = drop_reg;
                        drop_next          = 1'b0;
                    end
                end
            end
            ST_INS:
            begin
                if (!dup)
                begin
                    if (full)
                    begin
                        drop_next = 1'b1;
                    end
                    else
                    begin
                        ctl.ins = 1'b1;
                    end
                end
            end
            ST_FLUSH:
            begin
                ctl.shl            = 1'b1;
                strobe_next        = 1'b1;
                res_next.value_res = val_w[0];
                res_next.last      = !valid_w[1];
                res_next.empty_res = 1'b0;
                res_next.overflow  = drop_reg;
                if (!valid_w[1])
                begin
                    drop_next = 1'b0;
                end
            end
            default:
            begin
                ctl = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        ins_reg <= ins_next;
        res_reg <= res_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            drop_reg   <= 1'b0;
            strobe_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            drop_reg   <= drop_next;
            strobe_reg <= strobe_next;
        end
    end

endmodule

// ----- verif/sorted_distinct_union_set_unit_tb.sv -----
// ----------------------------------------------------------------------------
// sorted_distinct_union_set_unit_tb
// Self-checking bench for the sorted distinct union set unit. Insert and
// flush words go in via start/busy, random idle gaps outside back-to-back.
// A behavioral set tracks what each flush should drain, and every strobed
// result word is compared against that, field by field and in order.
// ----------------------------------------------------------------------------
module sorted_distinct_union_set_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import sdu_pkg::*;

    localparam int unsigned CAP          = 64;
    localparam int unsigned TARGET_CMDS  = 350;
    localparam int unsigned QUIET_LIMIT  = 2000;
    localparam int unsigned DRAIN_CYCLES = CAP + 8;

    logic       clk;
    logic       rst_n;
    logic       start;
    logic       busy;
    cmd_word_t  cmd;
    logic       strobe;
    res_word_t  res;

    logic signed [DATA_W-1:0] held_values[$];
    logic                     held_dropped;
    res_word_t                union_words_due[$];
    res_word_t                due_word;

    bit steady;
    int errors;
    int cmds_sent;
    int flushes;
    int empty_flushes;
    int overflow_flushes;
    int words_seen;
    int quiet_cycles;

    sorted_distinct_union_set_unit #(.CAPACITY(CAP)) dut
    (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .cmd    (cmd),
        .strobe (strobe),
        .res    (res)
    );

    always
    begin
        clk = 1'b0;
        #5;
        clk = 1'b1;
        #5;
    end

    function automatic void predict_command(input cmd_word_t c);
        int                       pos;
        logic signed [DATA_W-1:0] v;
        res_word_t                w;
        v = c.value;
        if (c.kind == KIND_INSERT)
        begin
            pos = 0;
            while (pos < held_values.size() && held_values[pos] < v)
                pos++;
            if (pos < held_values.size() && held_values[pos] == v)
                return;
            if (held_values.size() >= CAP)
            begin
                held_dropped = 1'b1;
                return;
            end
            held_values.insert(pos, v);
        end
        else
        begin
            flushes++;
            if (held_dropped)
                overflow_flushes++;
            if (held_values.size() == 0)
            begin
                empty_flushes++;
                w.value_res = '0;
                w.last      = 1'b1;
                w.empty_res = 1'b1;
                w.overflow  = held_dropped;
                union_words_due.insert(union_words_due.size(), w);
            end
            else
            begin
                foreach (held_values[i])
                begin
                    w.value_res = held_values[i];
                    w.last      = (i == held_values.size() - 1);
                    w.empty_res = 1'b0;
                    w.overflow  = held_dropped;
                    union_words_due.insert(union_words_due.size(), w);
                end
            end
            held_values.delete();
            held_dropped = 1'b0;
        end
    endfunction

    task automatic send_word(input kind_t k, input logic signed [DATA_W-1:0] v);
        int        gap;
        cmd_word_t c;
        c.kind  = k;
        c.value = v;
        gap = 0;
        if (!steady && $urandom_range(99) < 36)
            gap = ($urandom_range(9) == 0) ? $urandom_range(12, 5) : $urandom_range(3, 1);
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        start <= 1'b1;
        cmd   <= c;
        do @(posedge clk); while (busy);
        predict_command(c);
        cmds_sent++;
    endtask

    function automatic logic signed [DATA_W-1:0] pick_value
        (input logic signed [DATA_W-1:0] recent[$]);
        int                       sel;
        logic signed [DATA_W-1:0] v;
        sel = $urandom_range(99);
        if (sel < 35)
        begin
            v = $urandom_range(31);
            v = v - 16;
        end
        else if (sel < 55 && recent.size() > 0)
            v = recent[$urandom_range(recent.size() - 1)];
        else if (sel < 65)
        begin
            case ($urandom_range(3))
                0:       v = 32'sh8000_0000;
                1:       v = 32'sh7FFF_FFFF;
                2:       v = '0;
                default: v = -1;
            endcase
        end
        else
            v = $urandom;
        return v;
    endfunction

    task automatic run_set(input int size);
        logic signed [DATA_W-1:0] recent[$];
        logic signed [DATA_W-1:0] v;
        for (int i = 0; i < size; i++)
        begin
            v = pick_value(recent);
            recent.insert(recent.size(), v);
            send_word(KIND_INSERT, v);
        end
        send_word(KIND_FLUSH, $urandom);
    endtask

    task automatic test_directed();
        send_word(KIND_FLUSH, 32'sh7FFF_FFFF);
        send_word(KIND_INSERT, 32'sh7FFF_FFFF);
        send_word(KIND_INSERT, 32'sh8000_0000);
        send_word(KIND_INSERT, 0);
        send_word(KIND_INSERT, -1);
        send_word(KIND_INSERT, 1);
        send_word(KIND_INSERT, -1);
        send_word(KIND_INSERT, 32'sh7FFF_FFFF);
        send_word(KIND_INSERT, 32'sh5555_5555);
        send_word(KIND_INSERT, 32'shAAAA_AAAA);
        send_word(KIND_FLUSH, 32'sh0000_0000);
        send_word(KIND_INSERT, 5);
        send_word(KIND_FLUSH, 32'shFFFF_FFFF);
        send_word(KIND_FLUSH, 32'sh1234_5678);
    endtask

    task automatic test_full_store();
        for (int i = 0; i < CAP; i++)
            send_word(KIND_INSERT, (i % 2) ? i * 1000003 : -i * 999983 - 7);
        send_word(KIND_INSERT, -7);
        send_word(KIND_INSERT, 32'sh7FFF_FFFF);
        send_word(KIND_INSERT, 32'sh8000_0000);
        send_word(KIND_FLUSH, '0);
        send_word(KIND_FLUSH, '0);
        for (int i = CAP; i > 0; i--)
            send_word(KIND_INSERT, i * 65537);
        send_word(KIND_INSERT, 65537);
        send_word(KIND_FLUSH, '0);
        send_word(KIND_INSERT, 3);
        send_word(KIND_INSERT, 3);
        send_word(KIND_FLUSH, '0);
    endtask

    task automatic test_back_to_back();
        steady = 1'b1;
        repeat (6)
            run_set($urandom_range(10));
        steady = 1'b0;
    endtask

    task automatic test_random_sets();
        while (cmds_sent < TARGET_CMDS)
        begin
            if ($urandom_range(9) == 0)
                send_word(kind_t'($urandom_range(1)), $urandom);
            else if ($urandom_range(99) < 8)
                run_set($urandom_range(CAP + 6, 40));
            else
                run_set($urandom_range(12));
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && strobe)
        begin
            words_seen++;
            if (union_words_due.size() == 0)
            begin
                $error("unexpected result word: value_res %0d", res.value_res);
                errors++;
            end
            else
            begin
                due_word = union_words_due.pop_front();
                if (res.value_res !== due_word.value_res)
                begin
                    $error("value_res: expected %0d, got %0d", due_word.value_res,
                           res.value_res);
                    errors++;
                end
                if (res.last !== due_word.last)
                begin
                    $error("last: expected %0b, got %0b", due_word.last, res.last);
                    errors++;
                end
                if (res.empty_res !== due_word.empty_res)
                begin
                    $error("empty_res: expected %0b, got %0b", due_word.empty_res,
                           res.empty_res);
                    errors++;
                end
                if (res.overflow !== due_word.overflow)
                begin
                    $error("overflow: expected %0b, got %0b", due_word.overflow,
                           res.overflow);
                    errors++;
                end
            end
        end
        if ((start && !busy) || strobe)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("timeout: %0d cycles with no word moved", QUIET_LIMIT);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    initial
    begin
        rst_n        = 1'b0;
        start        = 1'b0;
        cmd          = '0;
        held_dropped = 1'b0;
        steady       = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_full_store();
        test_back_to_back();
        test_random_sets();

        start <= 1'b0;
        while (union_words_due.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d commands, %0d of them flushes (%0d empty, %0d with overflow)",
                 cmds_sent, flushes, empty_flushes, overflow_flushes);
        $display("Checked %0d result words, %0d mismatches", words_seen, errors);
        if (errors == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule
